@@ design/disk_request_scheduler_macros.svh @@
// Assertion helpers for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_MACROS_SVH

`define DRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/drs_pkg.sv @@
package drs_pkg;

  localparam int unsigned TRACK_W = 16;
  localparam int unsigned TOTAL_W = 22;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_SCAN  = 2'd2,
    POL_CSCAN = 2'd3
  } policy_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store the input track
    logic run_start;  // latch head, clear served flags and total
    logic scan_start; // reset search for a new pick
    logic scan_step;  // examine one entry
    logic commit;     // serve the chosen entry, build result
    logic dir_down;   // flip upward flag to downward
    logic batch_clear;
  } drs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // last entry examined
    logic found;      // search found a candidate
    logic empty;      // no stored requests
    logic upward;     // current sweep direction for SCAN family
    logic more;       // unserved entries remain after commit
  } drs_sts_t;

endpackage

@@ design/drs_datapath.sv @@
module drs_datapath #(
  parameter int unsigned MAX_REQUESTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drs_pkg::drs_cmd_t            cmd,
  output drs_pkg::drs_sts_t            sts,
  input  logic [1:0]                   policy,
  input  logic [drs_pkg::TRACK_W-1:0]  in_track,
  input  logic [drs_pkg::TRACK_W-1:0]  in_head,
  output logic [drs_pkg::TRACK_W-1:0]  res_track,
  output logic [drs_pkg::TRACK_W-1:0]  res_dist,
  output logic [drs_pkg::TOTAL_W-1:0]  res_total
);
  import drs_pkg::*;

  localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned POS_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  logic [TRACK_W-1:0] mem [MAX_REQUESTS];
  logic [TRACK_W-1:0] rd_data_r;
  logic [MAX_REQUESTS-1:0] served_r, served_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] served_cnt_r, served_cnt_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;   // address being read
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt; // index of rd_data_r
  logic cmp_vld_r, cmp_vld_nxt;
  logic [TRACK_W-1:0] head_r, head_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic upward_r, upward_nxt;
  logic found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [TRACK_W-1:0] best_trk_r, best_trk_nxt;
  logic [TRACK_W-1:0] best_key_r, best_key_nxt;
  logic [TRACK_W-1:0] dist_r, dist_nxt;

  logic [TRACK_W-1:0] cand_dist, cand_key, best_d;
  logic cand_ok, better, last_read;
  logic [TOTAL_W:0] sum;

  always_ff @(posedge clk) begin
    if (cmd.load && count_r != CNT_MAX) mem[count_r[IDX_W-1:0]] <= in_track;
    rd_data_r <= mem[rd_idx_r];
  end

  assign cand_dist = (rd_data_r >= head_r) ? rd_data_r - head_r : head_r - rd_data_r;
  assign last_read = ({1'b0, rd_idx_r} + 1'b1) >= POS_W'(count_r);

  always_comb begin
    cand_ok  = cmp_vld_r && !served_r[cmp_idx_r];
    cand_key = rd_data_r;
    better   = 1'b0;
    unique case (policy)
      POL_FCFS: begin
        better = !found_r;
      end
      POL_SSTF: begin
        cand_key = cand_dist;
        better   = !found_r || cand_dist < best_key_r;
      end
      default: begin
        if (upward_r) begin
          cand_ok = cand_ok && rd_data_r >= head_r;
          better  = !found_r || rd_data_r < best_key_r;
        end else if (policy == POL_SCAN) begin
          better = !found_r || rd_data_r > best_key_r;
        end else begin
          better = !found_r || rd_data_r < best_key_r;
        end
      end
    endcase
  end

  assign best_d = (best_trk_r >= head_r) ? best_trk_r - head_r : head_r - best_trk_r;
  assign sum = {1'b0, total_r} + {{(TOTAL_W - TRACK_W + 1){1'b0}}, best_d};

  always_comb begin
    count_nxt      = count_r;
    served_nxt     = served_r;
    served_cnt_nxt = served_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    head_nxt       = head_r;
    total_nxt      = total_r;
    upward_nxt     = upward_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_trk_nxt   = best_trk_r;
    best_key_nxt   = best_key_r;
    dist_nxt       = dist_r;
    if (cmd.load && count_r != CNT_MAX) count_nxt = count_r + 1'b1;
    if (cmd.run_start) begin
      head_nxt       = in_head;
      total_nxt      = '0;
      served_nxt     = '0;
      served_cnt_nxt = '0;
      upward_nxt     = 1'b1;
    end
    if (cmd.scan_start) begin
      rd_idx_nxt = '0;
      found_nxt  = 1'b0;
    end
    if (cmd.scan_step) begin
      cmp_idx_nxt = rd_idx_r;
      cmp_vld_nxt = 1'b1;
      if (!last_read) rd_idx_nxt = rd_idx_r + 1'b1;
    end
    if (cmp_vld_r && cand_ok && better) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_trk_nxt = rd_data_r;
      best_key_nxt = cand_key;
    end
    if (cmd.dir_down) upward_nxt = 1'b0;
    if (cmd.commit) begin
      served_nxt[best_idx_r] = 1'b1;
      served_cnt_nxt = served_cnt_r + 1'b1;
      head_nxt  = best_trk_r;
      dist_nxt  = best_d;
      total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
    if (cmd.batch_clear) count_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      served_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      upward_r  <= 1'b1;
      head_r    <= '0;
      total_r   <= '0;
      served_cnt_r <= '0;
    end else begin
      count_r   <= count_nxt;
      served_r  <= served_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      found_r   <= found_nxt;
      upward_r  <= upward_nxt;
      head_r    <= head_nxt;
      total_r   <= total_nxt;
      served_cnt_r <= served_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_trk_r <= best_trk_nxt;
    best_key_r <= best_key_nxt;
    dist_r     <= dist_nxt;
  end

  always_comb begin
    sts.scan_done = last_read;
    sts.found     = found_r;
    sts.empty     = count_r == '0;
    sts.upward    = upward_r;
    sts.more      = served_cnt_r != count_r;
  end

  assign res_track = head_r;
  assign res_dist  = dist_r;
  assign res_total = total_r;
endmodule

@@ design/drs_ctrl.sv @@
module drs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_func,
  input  drs_pkg::drs_sts_t sts,
  output drs_pkg::drs_cmd_t cmd,
  output logic              in_ready,
  output logic              emit,
  output logic              emit_last,
  input  logic              out_free
);
  import drs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    emit      = 1'b0;
    emit_last = !sts.more;
    in_ready  = state_r == ST_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.run_start = 1'b1;
            if (sts.empty) cmd.batch_clear = 1'b1;
            else state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.scan_start = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (sts.found) begin
          cmd.commit = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          // upward sweep exhausted: rescan in the other direction
          cmd.dir_down = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (sts.more) begin
            state_nxt = ST_START;
          end else begin
            cmd.batch_clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule

@@ design/disk_request_scheduler.sv @@
// Load beat: stores the track (dropped when the batch is full), no result.
// Run beat: each result needs one pass over the stored requests through the store's
// registered read port, then a pick; SCAN/C-SCAN add one more pass when the upward
// sweep runs dry. A finished result sits in an output register.
// Reset (rst_n low, synchronous) empties the batch, sets policy to first-come.
`include "disk_request_scheduler_macros.svh"
module disk_request_scheduler #(
  parameter int unsigned MAX_REQUESTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // track[15:0], head[31:16]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // served_track[15:0], seek_distance[31:16],
                                  // total_seek[53:32], zero fill
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data // policy
);
  import drs_pkg::*;

  logic [1:0] policy_r;
  drs_cmd_t cmd;
  drs_sts_t sts;
  logic in_fire, emit, emit_last, out_free;
  logic [TRACK_W-1:0] res_track, res_dist;
  logic [TOTAL_W-1:0] res_total;
  logic out_valid_r;
  logic [55:0] out_data_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) policy_r <= POL_FCFS;
    else if (cfg_wr_en) policy_r <= cfg_wr_data;
  end

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  drs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_func(in_tuser), .sts, .cmd,
    .in_ready(in_tready), .emit, .emit_last, .out_free
  );

  drs_datapath #(.MAX_REQUESTS(MAX_REQUESTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .policy(policy_r),
    .in_track(in_tdata[15:0]), .in_head(in_tdata[31:16]),
    .res_track, .res_dist, .res_total
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {2'b00, res_total, res_dist, res_track};
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `DRS_ASSERT_IMPL(a_no_emit_when_full, clk, rst_n, emit, out_free, "result overwritten")
  `DRS_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, emit, out_tvalid, "emitted beat lost")
  `DRS_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, out_tvalid && !out_tlast, !in_tready,
                   "input taken mid run")
endmodule
